// ----- src/clip_rectangle_stack_core_assert.svh -----
// Assertion macros for the clip rectangle stack core.
`ifndef CLIP_RECTANGLE_STACK_CORE_ASSERT_SVH
`define CLIP_RECTANGLE_STACK_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define CRS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clip stack assertion failed");

// Delayed implication, checked while out of reset
`define CRS_ASSERT_AFTER2(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("clip stack latency assertion failed");

`endif

// ----- src/crs_pkg.sv -----
// Shared types and constants of the clip rectangle stack.
package crs_pkg;

    // Deepest stack level; entries 0 .. MAX_LEVEL exist
    localparam int MAX_LEVEL = 15;
    localparam int DEPTH     = MAX_LEVEL + 1;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEVEL_W   = 4;
    localparam int EDGE_W    = 17;
    localparam int SIZE_W    = 18;

    typedef enum logic [2:0] {
        OP_PUSH_RECT    = 3'd0,
        OP_PUSH_NO_CLIP = 3'd1,
        OP_POP          = 3'd2,
        OP_REPLACE      = 3'd3,
        OP_CLIP_BOX     = 3'd4,
        OP_VISIBILITY   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CLS_EMPTY = 2'd0,
        CLS_SAME  = 2'd1,
        CLS_LESS  = 2'd2
    } t_cls;

    // Rectangle as left, top, right and bottom edges
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
    } t_rect;

    // Intersection result: tightened rectangle and its class
    typedef struct packed {
        t_rect rect;
        t_cls  cls;
    } t_isect;

endpackage

// ----- src/crs_intersect.sv -----
// Intersection of a rectangle with the clip rectangle, with classification.
module crs_intersect (
    input  crs_pkg::t_rect  i_a,
    input  crs_pkg::t_rect  i_c,
    output crs_pkg::t_isect o_res
);

    logic           a_empty;
    logic           c_empty;
    logic           same;
    logic           t_empty;
    crs_pkg::t_rect tight;

    assign a_empty = ($signed(i_a.right) <= $signed(i_a.left)) ||
                     ($signed(i_a.bottom) <= $signed(i_a.top));
    assign c_empty = ($signed(i_c.right) <= $signed(i_c.left)) ||
                     ($signed(i_c.bottom) <= $signed(i_c.top));

    // left/top take the max, right/bottom the min
    always_comb begin
        tight.left   = ($signed(i_c.left) > $signed(i_a.left)) ? i_c.left : i_a.left;
        tight.top    = ($signed(i_c.top) > $signed(i_a.top)) ? i_c.top : i_a.top;
        tight.right  = ($signed(i_c.right) < $signed(i_a.right)) ? i_c.right : i_a.right;
        tight.bottom = ($signed(i_c.bottom) < $signed(i_a.bottom)) ? i_c.bottom : i_a.bottom;
    end

    assign same    = (i_a == i_c);
    assign t_empty = ($signed(tight.right) <= $signed(tight.left)) ||
                     ($signed(tight.bottom) <= $signed(tight.top));

    always_comb begin
        if (a_empty) begin
            o_res.rect = i_a;
            o_res.cls  = crs_pkg::CLS_EMPTY;
        end else if (c_empty) begin
            o_res.rect = '0;
            o_res.cls  = crs_pkg::CLS_EMPTY;
        end else begin
            o_res.rect = tight;
            if (same) begin
                o_res.cls = crs_pkg::CLS_SAME;
            end else if (t_empty) begin
                o_res.cls = crs_pkg::CLS_EMPTY;
            end else begin
                o_res.cls = crs_pkg::CLS_LESS;
            end
        end
    end

endmodule

// ----- src/clip_rectangle_stack_core.sv -----
// Top level of the clip rectangle stack: input beat register, stack, result register.
//
// Takes one command beat per clock; busy is always low. Each accepted beat gives exactly
// one result beat. o_strobe is registered and rises at the edge after the accepting edge;
// it holds for one cycle.
// The receiver cannot stall, and none is needed: the stack top is read and written in the
// same stage, so a command sees every earlier command's update with no gap. The rate is
// set by one pass through the intersect compares and the box subtraction. No clearing
// pass follows reset; the stack takes commands as soon as reset is released.
`include "clip_rectangle_stack_core_assert.svh"

module clip_rectangle_stack_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_operation,
    input  logic signed [15:0]                   i_rect_x,
    input  logic signed [15:0]                   i_rect_y,
    input  logic signed [15:0]                   i_rect_w,
    input  logic signed [15:0]                   i_rect_h,
    input  logic                                 i_set_no_clip,
    output logic                                 o_strobe,
    output logic signed [crs_pkg::EDGE_W-1:0]    o_box_x,
    output logic signed [crs_pkg::EDGE_W-1:0]    o_box_y,
    output logic signed [crs_pkg::SIZE_W-1:0]    o_box_w,
    output logic signed [crs_pkg::SIZE_W-1:0]    o_box_h,
    output logic                                 o_box_changed,
    output logic [1:0]                           o_visibility,
    output logic                                 o_overflow,
    output logic                                 o_underflow,
    output logic [crs_pkg::LEVEL_W-1:0]          o_stack_level,
    output logic                                 o_top_is_no_clip
);

    localparam logic [crs_pkg::IDX_W-1:0] TOP_MAX = crs_pkg::IDX_W'(crs_pkg::MAX_LEVEL);
    localparam logic [crs_pkg::IDX_W-1:0] IDX_ONE = crs_pkg::IDX_W'(1);

    // Input beat register
    logic                 r_in_valid;
    crs_pkg::t_op         r_op;
    crs_pkg::t_rect       r_a;
    logic                 r_w_pos;
    logic                 r_h_pos;
    logic                 r_nc_in;

    // Stack state
    crs_pkg::t_rect              r_stack [crs_pkg::DEPTH];
    logic [crs_pkg::DEPTH-1:0]   r_nc;
    logic [crs_pkg::IDX_W-1:0]   r_top;

    // Result register
    logic                               r_strobe;
    logic signed [crs_pkg::EDGE_W-1:0]  r_box_x;
    logic signed [crs_pkg::EDGE_W-1:0]  r_box_y;
    logic signed [crs_pkg::SIZE_W-1:0]  r_box_w;
    logic signed [crs_pkg::SIZE_W-1:0]  r_box_h;
    logic                               r_box_changed;
    logic [1:0]                         r_visibility;
    logic                               r_overflow;
    logic                               r_underflow;

    // Next values
    logic [crs_pkg::IDX_W-1:0]          n_top;
    logic                               n_wr_en;
    logic [crs_pkg::IDX_W-1:0]          n_wr_idx;
    crs_pkg::t_rect                     n_wr_rect;
    logic                               n_wr_nc;
    crs_pkg::t_rect                     n_box;
    logic signed [crs_pkg::EDGE_W-1:0]  n_box_x;
    logic signed [crs_pkg::EDGE_W-1:0]  n_box_y;
    logic signed [crs_pkg::SIZE_W-1:0]  n_box_w;
    logic signed [crs_pkg::SIZE_W-1:0]  n_box_h;
    logic                               n_box_changed;
    logic [1:0]                         n_visibility;
    logic                               n_overflow;
    logic                               n_underflow;

    crs_pkg::t_rect  top_rect;
    logic            top_nc;
    crs_pkg::t_isect isect;
    logic            full;

    assign busy = 1'b0;

    // Register the command; right and bottom edges are formed here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_op         <= crs_pkg::t_op'(i_operation);
        r_a.left     <= crs_pkg::EDGE_W'(i_rect_x);
        r_a.top      <= crs_pkg::EDGE_W'(i_rect_y);
        r_a.right    <= crs_pkg::EDGE_W'(i_rect_x) + crs_pkg::EDGE_W'(i_rect_w);
        r_a.bottom   <= crs_pkg::EDGE_W'(i_rect_y) + crs_pkg::EDGE_W'(i_rect_h);
        r_w_pos      <= (i_rect_w > 16'sd0);
        r_h_pos      <= (i_rect_h > 16'sd0);
        r_nc_in      <= i_set_no_clip;
    end

    assign top_rect = r_stack[r_top];
    assign top_nc   = r_nc[r_top];
    assign full     = (r_top == TOP_MAX);

    crs_intersect u_isect (
        .i_a   (r_a),
        .i_c   (top_rect),
        .o_res (isect)
    );

    // Command decode against the stack top
    always_comb begin
        n_top         = r_top;
        n_wr_en       = 1'b0;
        n_wr_idx      = r_top;
        n_wr_rect     = r_a;
        n_wr_nc       = 1'b0;
        n_box         = '0;
        n_box_changed = 1'b0;
        n_visibility  = 2'd0;
        n_overflow    = 1'b0;
        n_underflow   = 1'b0;
        case (r_op)
            crs_pkg::OP_PUSH_RECT: begin
                if (!(r_w_pos && r_h_pos)) begin
                    n_wr_rect = '0;
                end else if (!top_nc) begin
                    n_wr_rect = isect.rect;
                end
                if (full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_top    = r_top + IDX_ONE;
                    n_wr_idx = r_top + IDX_ONE;
                    n_wr_en  = r_in_valid;
                end
            end
            crs_pkg::OP_PUSH_NO_CLIP: begin
                n_wr_nc = 1'b1;
                if (full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_top    = r_top + IDX_ONE;
                    n_wr_idx = r_top + IDX_ONE;
                    n_wr_en  = r_in_valid;
                end
            end
            crs_pkg::OP_POP: begin
                if (r_top == '0) begin
                    n_underflow = 1'b1;
                end else begin
                    n_top = r_top - IDX_ONE;
                end
            end
            crs_pkg::OP_REPLACE: begin
                n_wr_nc = r_nc_in;
                n_wr_en = r_in_valid;
            end
            crs_pkg::OP_CLIP_BOX: begin
                if (top_nc) begin
                    n_box = r_a;
                end else begin
                    n_box         = isect.rect;
                    n_box_changed = (isect.cls != crs_pkg::CLS_SAME);
                end
            end
            crs_pkg::OP_VISIBILITY: begin
                if (!(r_w_pos && r_h_pos)) begin
                    n_visibility = 2'(crs_pkg::CLS_EMPTY);
                end else if (top_nc) begin
                    n_visibility = 2'(crs_pkg::CLS_SAME);
                end else begin
                    n_visibility = 2'(isect.cls);
                end
            end
            default: begin
            end
        endcase
    end

    // Box width and height from edges
    assign n_box_x = n_box.left;
    assign n_box_y = n_box.top;
    assign n_box_w = crs_pkg::SIZE_W'(n_box.right) - crs_pkg::SIZE_W'(n_box.left);
    assign n_box_h = crs_pkg::SIZE_W'(n_box.bottom) - crs_pkg::SIZE_W'(n_box.top);

    // Stack control and no-clip marks; entry zero starts as no-clip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_nc[0]  <= 1'b1;
        end else if (r_in_valid) begin
            r_top <= n_top;
            if (n_wr_en) begin
                r_nc[n_wr_idx] <= n_wr_nc;
            end
        end
    end

    // Stack edges, no reset
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_stack[n_wr_idx] <= n_wr_rect;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_in_valid;
        end
        r_box_x       <= n_box_x;
        r_box_y       <= n_box_y;
        r_box_w       <= n_box_w;
        r_box_h       <= n_box_h;
        r_box_changed <= n_box_changed;
        r_visibility  <= n_visibility;
        r_overflow    <= n_overflow;
        r_underflow   <= n_underflow;
    end

    assign o_strobe         = r_strobe;
    assign o_box_x          = r_box_x;
    assign o_box_y          = r_box_y;
    assign o_box_w          = r_box_w;
    assign o_box_h          = r_box_h;
    assign o_box_changed    = r_box_changed;
    assign o_visibility     = r_visibility;
    assign o_overflow       = r_overflow;
    assign o_underflow      = r_underflow;
    // level and mark come from the stack state the beat left behind
    assign o_stack_level    = crs_pkg::LEVEL_W'(r_top);
    assign o_top_is_no_clip = r_nc[r_top];

    // Checks
    `CRS_ASSERT_AFTER2(a_beat_latency, start && !busy, o_strobe)
    `CRS_ASSERT_IMPLY(a_underflow_level, o_strobe && o_underflow, r_top == '0)
    `CRS_ASSERT_IMPLY(a_overflow_level, o_strobe && o_overflow, r_top == TOP_MAX)
    `CRS_ASSERT_IMPLY(a_flags_exclusive, o_strobe, !(o_overflow && o_underflow))
    `CRS_ASSERT_IMPLY(a_vis_no_box, o_strobe && (o_visibility != 2'(crs_pkg::CLS_EMPTY)),
                      (o_box_w == '0) && (o_box_h == '0) && !o_box_changed)
    `CRS_ASSERT_IMPLY(a_top_bound, 1'b1, r_top <= TOP_MAX)

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the clip rectangle stack core: directed, limit and random tests.
`timescale 1ns / 100ps

module testbench;

    // Operation codes the package leaves unnamed; the block must ignore them
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT   = 250000;
    localparam int RESULT_LAT    = 2;
    localparam int MAX_PRINTED   = 40;

    // Edges widened to int for the intersection math
    typedef struct {
        int left;
        int top;
        int right;
        int bottom;
    } t_edges;

    // One expected result beat
    typedef struct {
        logic signed [crs_pkg::EDGE_W-1:0]  box_x;
        logic signed [crs_pkg::EDGE_W-1:0]  box_y;
        logic signed [crs_pkg::SIZE_W-1:0]  box_w;
        logic signed [crs_pkg::SIZE_W-1:0]  box_h;
        logic                               box_changed;
        logic [1:0]                         visibility;
        logic                               overflow;
        logic                               underflow;
        logic [crs_pkg::LEVEL_W-1:0]        stack_level;
        logic                               top_is_no_clip;
    } t_clip_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Command side
    logic                start = 1'b0;
    logic                busy;
    logic [2:0]          cmd_op = '0;
    logic signed [15:0]  cmd_x = '0;
    logic signed [15:0]  cmd_y = '0;
    logic signed [15:0]  cmd_w = '0;
    logic signed [15:0]  cmd_h = '0;
    logic                cmd_no_clip = 1'b0;

    // Result side
    logic                                res_strobe;
    logic signed [crs_pkg::EDGE_W-1:0]   res_box_x;
    logic signed [crs_pkg::EDGE_W-1:0]   res_box_y;
    logic signed [crs_pkg::SIZE_W-1:0]   res_box_w;
    logic signed [crs_pkg::SIZE_W-1:0]   res_box_h;
    logic                                res_box_changed;
    logic [1:0]                          res_visibility;
    logic                                res_overflow;
    logic                                res_underflow;
    logic [crs_pkg::LEVEL_W-1:0]         res_stack_level;
    logic                                res_top_is_no_clip;

    // Mirror of the stack contents
    logic signed [crs_pkg::EDGE_W-1:0]  mirror_left   [crs_pkg::DEPTH];
    logic signed [crs_pkg::EDGE_W-1:0]  mirror_top    [crs_pkg::DEPTH];
    logic signed [crs_pkg::EDGE_W-1:0]  mirror_right  [crs_pkg::DEPTH];
    logic signed [crs_pkg::EDGE_W-1:0]  mirror_bottom [crs_pkg::DEPTH];
    logic                               mirror_no_clip[crs_pkg::DEPTH];
    int                                 mirror_level;

    t_clip_result pending_results[$];
    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  idle_pct = 0;
    bit  rising = 1'b1;

    clip_rectangle_stack_core DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (cmd_op),
        .i_rect_x         (cmd_x),
        .i_rect_y         (cmd_y),
        .i_rect_w         (cmd_w),
        .i_rect_h         (cmd_h),
        .i_set_no_clip    (cmd_no_clip),
        .o_strobe         (res_strobe),
        .o_box_x          (res_box_x),
        .o_box_y          (res_box_y),
        .o_box_w          (res_box_w),
        .o_box_h          (res_box_h),
        .o_box_changed    (res_box_changed),
        .o_visibility     (res_visibility),
        .o_overflow       (res_overflow),
        .o_underflow      (res_underflow),
        .o_stack_level    (res_stack_level),
        .o_top_is_no_clip (res_top_is_no_clip)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stack predictor
    // ------------------------------------------------------------------

    function automatic bit rect_is_void(input t_edges e);
        return (e.right <= e.left) || (e.bottom <= e.top);
    endfunction

    function automatic t_edges top_edges();
        t_edges e;
        e.left   = int'(mirror_left[mirror_level]);
        e.top    = int'(mirror_top[mirror_level]);
        e.right  = int'(mirror_right[mirror_level]);
        e.bottom = int'(mirror_bottom[mirror_level]);
        return e;
    endfunction

    // Tightens a against clip c and classifies the outcome
    function automatic crs_pkg::t_cls intersect_edges(inout t_edges a, input t_edges c);
        bit differ;
        differ = 1'b0;
        if (rect_is_void(a))
            return crs_pkg::CLS_EMPTY;
        if (rect_is_void(c)) begin
            a = '{0, 0, 0, 0};
            return crs_pkg::CLS_EMPTY;
        end
        if (a.left != c.left) begin
            differ = 1'b1;
            if (c.left > a.left) a.left = c.left;
        end
        if (a.top != c.top) begin
            differ = 1'b1;
            if (c.top > a.top) a.top = c.top;
        end
        if (a.right != c.right) begin
            differ = 1'b1;
            if (c.right < a.right) a.right = c.right;
        end
        if (a.bottom != c.bottom) begin
            differ = 1'b1;
            if (c.bottom < a.bottom) a.bottom = c.bottom;
        end
        if (!differ)
            return crs_pkg::CLS_SAME;
        return rect_is_void(a) ? crs_pkg::CLS_EMPTY : crs_pkg::CLS_LESS;
    endfunction

    function automatic void write_top(input t_edges e, input logic no_clip);
        mirror_left[mirror_level]    = crs_pkg::EDGE_W'(e.left);
        mirror_top[mirror_level]     = crs_pkg::EDGE_W'(e.top);
        mirror_right[mirror_level]   = crs_pkg::EDGE_W'(e.right);
        mirror_bottom[mirror_level]  = crs_pkg::EDGE_W'(e.bottom);
        mirror_no_clip[mirror_level] = no_clip;
    endfunction

    function automatic logic push_entry(input t_edges e, input logic no_clip);
        if (mirror_level >= crs_pkg::MAX_LEVEL)
            return 1'b1;
        mirror_level++;
        write_top(e, no_clip);
        return 1'b0;
    endfunction

    // Applies one accepted command to the mirror and queues its result
    function automatic void predict_stack_command(input logic [2:0] op,
                                                  input logic signed [15:0] x, y, w, h,
                                                  input logic no_clip);
        t_edges a;
        crs_pkg::t_cls cls;
        t_clip_result res;
        a.left   = int'(x);
        a.top    = int'(y);
        a.right  = int'(x) + int'(w);
        a.bottom = int'(y) + int'(h);
        res = '{default: '0};
        case (op)
            crs_pkg::OP_PUSH_RECT: begin
                if (w > 0 && h > 0) begin
                    if (!mirror_no_clip[mirror_level])
                        cls = intersect_edges(a, top_edges());
                end else begin
                    a = '{0, 0, 0, 0};
                end
                res.overflow = push_entry(a, 1'b0);
            end
            crs_pkg::OP_PUSH_NO_CLIP: res.overflow = push_entry(a, 1'b1);
            crs_pkg::OP_POP: begin
                if (mirror_level > 0)
                    mirror_level--;
                else
                    res.underflow = 1'b1;
            end
            crs_pkg::OP_REPLACE: write_top(a, no_clip);
            crs_pkg::OP_CLIP_BOX: begin
                if (!mirror_no_clip[mirror_level]) begin
                    cls = intersect_edges(a, top_edges());
                    res.box_changed = (cls != crs_pkg::CLS_SAME);
                end
                res.box_x = crs_pkg::EDGE_W'(a.left);
                res.box_y = crs_pkg::EDGE_W'(a.top);
                res.box_w = crs_pkg::SIZE_W'(a.right - a.left);
                res.box_h = crs_pkg::SIZE_W'(a.bottom - a.top);
            end
            crs_pkg::OP_VISIBILITY: begin
                if (w <= 0 || h <= 0)
                    res.visibility = crs_pkg::CLS_EMPTY;
                else if (mirror_no_clip[mirror_level])
                    res.visibility = crs_pkg::CLS_SAME;
                else
                    res.visibility = intersect_edges(a, top_edges());
            end
            default: ;
        endcase
        res.stack_level    = crs_pkg::LEVEL_W'(mirror_level);
        res.top_is_no_clip = mirror_no_clip[mirror_level];
        pending_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one command beat, after an optional idle burst
    task automatic send_command(input logic [2:0] op, input int x, y, w, h,
                                input logic no_clip);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start       <= 1'b1;
        cmd_op      <= op;
        cmd_x       <= x[15:0];
        cmd_y       <= y[15:0];
        cmd_w       <= w[15:0];
        cmd_h       <= h[15:0];
        cmd_no_clip <= no_clip;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        predict_stack_command(op, x[15:0], y[15:0], w[15:0], h[15:0], no_clip);
    endtask

    // Lowers start and holds off until every result is back
    task automatic wait_until_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch: %s", what);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0d expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Result checker: every strobe must match the oldest prediction
    always @(posedge clk) begin : check_results
        t_clip_result want;
        if (rst_n && res_strobe) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = pending_results.pop_front();
                check_field("box_x", res_box_x, want.box_x);
                check_field("box_y", res_box_y, want.box_y);
                check_field("box_w", res_box_w, want.box_w);
                check_field("box_h", res_box_h, want.box_h);
                check_field("box_changed", res_box_changed, want.box_changed);
                check_field("visibility", res_visibility, want.visibility);
                check_field("overflow", res_overflow, want.overflow);
                check_field("underflow", res_underflow, want.underflow);
                check_field("stack_level", res_stack_level, want.stack_level);
                check_field("top_is_no_clip", res_top_is_no_clip, want.top_is_no_clip);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return int'($urandom_range(0, 240)) - 120;
        if (pick < 85) begin
            case ($urandom_range(0, 5))
                0: return -32768;
                1: return -32767;
                2: return -1;
                3: return 0;
                4: return 32766;
                default: return 32767;
            endcase
        end
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rand_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 150);
        if (pick < 82)
            return int'($urandom_range(0, 3)) - 3;
        if (pick < 90) begin
            case ($urandom_range(0, 3))
                0: return -32768;
                1: return 32767;
                2: return 32766;
                default: return 1;
            endcase
        end
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Special cases and every operation, from the reset state
    task automatic test_special_cases();
        idle_pct = 25;
        send_command(crs_pkg::OP_CLIP_BOX, -32768, 32767, 32767, -32768, 1'b0);  // no-clip box
        send_command(crs_pkg::OP_VISIBILITY, 5, 5, 10, 10, 1'b0);                 // visible
        send_command(crs_pkg::OP_VISIBILITY, 5, 5, 0, 10, 1'b0);                  // empty rect
        send_command(crs_pkg::OP_POP, 0, 0, 0, 0, 1'b0);                          // underflow
        send_command(crs_pkg::OP_PUSH_RECT, 0, 0, 100, 100, 1'b0);                // onto no-clip
        send_command(crs_pkg::OP_PUSH_RECT, 50, -20, 100, 60, 1'b0);              // tightened
        send_command(crs_pkg::OP_CLIP_BOX, 50, 0, 50, 40, 1'b0);                  // same as top
        send_command(crs_pkg::OP_CLIP_BOX, -10, -10, 200, 200, 1'b0);             // larger box
        send_command(crs_pkg::OP_CLIP_BOX, 500, 0, 20, 20, 1'b0);                 // disjoint
        send_command(crs_pkg::OP_CLIP_BOX, 60, 10, -5, 10, 1'b0);                 // empty box in
        send_command(crs_pkg::OP_VISIBILITY, 50, 0, 50, 40, 1'b0);                // same
        send_command(crs_pkg::OP_VISIBILITY, 40, 10, 30, 10, 1'b0);               // partial
        send_command(crs_pkg::OP_VISIBILITY, -300, 0, 10, 10, 1'b0);              // clipped away
        send_command(crs_pkg::OP_PUSH_RECT, 60, 10, 10, 0, 1'b0);                 // empty push
        send_command(crs_pkg::OP_CLIP_BOX, 60, 10, 10, 10, 1'b0);                 // empty top
        send_command(crs_pkg::OP_VISIBILITY, 60, 10, 10, 10, 1'b0);
        send_command(crs_pkg::OP_REPLACE, 30, 30, -20, 5, 1'b0);                  // unnormalized
        send_command(crs_pkg::OP_CLIP_BOX, 0, 0, 50, 50, 1'b0);
        send_command(crs_pkg::OP_REPLACE, 0, 0, 0, 0, 1'b1);                      // to no-clip
        send_command(crs_pkg::OP_PUSH_RECT, 32767, 32767, 32767, 32767, 1'b0);    // widest edges
        send_command(crs_pkg::OP_PUSH_NO_CLIP, 1, 2, 3, 4, 1'b0);
        send_command(OP_SPARE_6, 7, 7, 7, 7, 1'b1);
        send_command(OP_SPARE_7, -1, -1, -1, -1, 1'b1);
        repeat (4) send_command(crs_pkg::OP_POP, 0, 0, 0, 0, 1'b0);               // down to level 1
        send_command(crs_pkg::OP_REPLACE, -40, -40, 80, 80, 1'b0);                // at level 1
        send_command(crs_pkg::OP_CLIP_BOX, -32768, -32768, 32767, 32767, 1'b0);
    endtask

    // Fill to the top, push past it, then drain past level zero
    task automatic test_stack_limits();
        while (mirror_level < crs_pkg::MAX_LEVEL) begin
            if ($urandom_range(0, 3) == 0)
                send_command(crs_pkg::OP_PUSH_NO_CLIP, rand_coord(), rand_coord(),
                             rand_size(), rand_size(), 1'b0);
            else
                send_command(crs_pkg::OP_PUSH_RECT, rand_coord(), rand_coord(),
                             rand_size(), rand_size(), 1'b0);
        end
        send_command(crs_pkg::OP_PUSH_RECT, -10, -10, 20, 20, 1'b0);
        send_command(crs_pkg::OP_PUSH_NO_CLIP, 0, 0, 0, 0, 1'b1);
        send_command(crs_pkg::OP_REPLACE, -50, -50, 100, 100, 1'b0);
        send_command(crs_pkg::OP_VISIBILITY, 40, 40, 20, 20, 1'b0);
        send_command(crs_pkg::OP_PUSH_RECT, 0, 0, 10, 10, 1'b0);
        while (mirror_level > 0)
            send_command(crs_pkg::OP_POP, rand_coord(), 0, 0, 0, 1'b0);
        send_command(crs_pkg::OP_POP, 0, 0, 0, 0, 1'b1);
        send_command(crs_pkg::OP_POP, 0, 0, 0, 0, 1'b0);
    endtask

    // Random commands; level drifts up and down so both limits are hit
    task automatic test_random_traffic(input int count, input bit with_gaps);
        int r;
        int p_push;
        int p_pop;
        int x, y, w, h;
        logic [2:0] op;
        t_edges t;
        for (int n = 0; n < count; n++) begin
            if (with_gaps && n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 40;
                endcase
            end
            if ((mirror_level == crs_pkg::MAX_LEVEL && rising) ||
                (mirror_level == 0 && !rising)) begin
                if ($urandom_range(0, 99) < 30) rising = !rising;
            end else if ($urandom_range(0, 99) < 2) begin
                rising = !rising;
            end
            p_push = rising ? 32 : 10;
            p_pop  = rising ? 8 : 30;
            r = $urandom_range(0, 99);
            if (r < p_push)                    op = crs_pkg::OP_PUSH_RECT;
            else if (r < p_push + 5)           op = crs_pkg::OP_PUSH_NO_CLIP;
            else if (r < p_push + 5 + p_pop)   op = crs_pkg::OP_POP;
            else if (r < p_push + p_pop + 13)  op = crs_pkg::OP_REPLACE;
            else if (r < p_push + p_pop + 33)  op = crs_pkg::OP_CLIP_BOX;
            else if (r < p_push + p_pop + 53)  op = crs_pkg::OP_VISIBILITY;
            else                               op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            x = rand_coord();
            y = rand_coord();
            w = rand_size();
            h = rand_size();
            // Often aim at the current top exactly, or off by one in width, height or x
            t = top_edges();
            if ((op == crs_pkg::OP_PUSH_RECT || op == crs_pkg::OP_CLIP_BOX ||
                 op == crs_pkg::OP_VISIBILITY) &&
                !mirror_no_clip[mirror_level] && $urandom_range(0, 99) < 20 &&
                t.right - t.left >= -32768 && t.right - t.left <= 32767 &&
                t.bottom - t.top >= -32768 && t.bottom - t.top <= 32767) begin
                x = t.left;
                y = t.top;
                w = t.right - t.left;
                h = t.bottom - t.top;
                case ($urandom_range(0, 5))
                    0: w = w - 1;
                    1: h = h + 1;
                    2: x = x + 1;
                    default: ;
                endcase
            end
            send_command(op, x, y, w, h, $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        foreach (mirror_no_clip[i]) begin
            mirror_left[i]    = '0;
            mirror_top[i]     = '0;
            mirror_right[i]   = '0;
            mirror_bottom[i]  = '0;
            mirror_no_clip[i] = 1'b0;
        end
        mirror_no_clip[0] = 1'b1;
        mirror_level = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_stack_limits();
        test_random_traffic(700, 1'b1);
        wait_until_drained();
        test_stack_limits();
        test_random_traffic(600, 1'b1);
        idle_pct = 0;
        test_random_traffic(150, 1'b0);

        // Drain, then allow the pipeline to settle
        wait_until_drained();
        repeat (RESULT_LAT + 6) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
